FILE: sv/llq_pkg.sv
// Shared constants and controller/datapath interface types for the loop length quantizer.
package llq_pkg;

   localparam int unsigned CROSSFADE_LEN = 4;
   localparam int unsigned FLOOR_LEN     = CROSSFADE_LEN * 2;
   localparam int unsigned MULT_CAP      = 1 << 30;

   localparam int unsigned REC_W    = 31;
   localparam int unsigned BLOCK_W  = 32;
   localparam int unsigned MASTER_W = 31;
   localparam int unsigned CAND_W   = 32;
   localparam int unsigned SUB_W    = 2;

   typedef struct packed {
      logic load;
      logic step_sub;
      logic step_mult;
      logic enter_mult;
      logic take;
      logic load_out;
   } llq_cmd_type;

   typedef struct packed {
      logic master_zero;
      logic lt_floor;
      logic le_rec;
      logic round_up;
      logic over_cap;
      logic sub_last;
      logic out_free;
   } llq_status_type;

endpackage

FILE: sv/loop_length_quantizer.sv
// Top level of the loop length quantizer: controller plus datapath.
//
// req channel: one transaction carries recorded_blocks, start_block and stop_block.
// rsp channel: one transaction per request with target_blocks and fits_recorded.
// csr channel: writes master_blocks (0 selects the start/stop length); always ready;
//   the user must write it only while no request is in flight; the block does not check.
// Sequence: with no master length, the request goes straight to the result. With a
//   master length, the sub-division candidates (up to 4) are swept, then the master
//   length is doubled until it passes 2^30 or rounding settles, all through one shared
//   compare unit. One request is worked on at a time; the next is taken once the result
//   sits in the output register.
// Reset clears the master length to 0 and empties the output register.
// A stalled rsp holds the result; a finished next result then waits in the
//   controller until the output register frees up.
module loop_length_quantizer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [95:0] req_tdata,  // recorded_blocks[30:0], start_block[62:31], stop_block[94:63]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,  // target_blocks[30:0], fits_recorded[31]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [30:0] csr_data
);
   import llq_pkg::*;

   llq_cmd_type    cmd;
   llq_status_type status;

   assign csr_ready = 1'b1;

   llq_controller u_controller (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   llq_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_data   (csr_data),
      .cmd        (cmd),
      .status     (status)
   );

endmodule

FILE: sv/llq_datapath.sv
// Datapath: input and master registers, candidate generation, compares and result register.
module llq_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   input  logic [95:0]            req_tdata,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [31:0]            rsp_tdata,
   input  logic                   csr_valid,
   input  logic [30:0]            csr_data,
   input  llq_pkg::llq_cmd_type    cmd,
   output llq_pkg::llq_status_type status
);
   import llq_pkg::*;

   logic [MASTER_W-1:0] master_ff, master_in;
   logic [REC_W-1:0]    rec_ff;
   logic [BLOCK_W-1:0]  start_ff, stop_ff;
   logic [SUB_W-1:0]    sub_idx_ff, sub_idx_in;
   logic [CAND_W-1:0]   mult_cand_ff, mult_cand_in;
   logic                first_ff, first_in;
   logic                phase_mult_ff, phase_mult_in;
   logic [REC_W-1:0]    best_ff, best_in;
   logic [REC_W-1:0]    target_ff, target_in;
   logic                fits_ff, fits_in;
   logic                rsp_tvalid_ff, rsp_tvalid_in;

   logic [CAND_W-1:0]   sub_cand;
   logic [CAND_W-1:0]   cand_sel;
   logic [32:0]         mid_sum;
   logic [33:0]         rec_x5;
   logic [33:0]         cand_x3;
   logic                round_mid;
   logic                round_60;
   logic [BLOCK_W-1:0]  span;
   logic [REC_W-1:0]    clamp_len;
   logic [REC_W-1:0]    floor_len;
   logic [REC_W-1:0]    direct_len;

   always_comb begin
      case (sub_idx_ff)
         2'd0:    sub_cand = CAND_W'(FLOOR_LEN);
         2'd1:    sub_cand = CAND_W'(master_ff >> 3);
         2'd2:    sub_cand = CAND_W'(master_ff >> 2);
         2'd3:    sub_cand = CAND_W'(master_ff >> 1);
         default: sub_cand = CAND_W'(FLOOR_LEN);
      endcase
   end

   assign cand_sel  = phase_mult_ff ? mult_cand_ff : sub_cand;
   assign mid_sum   = 33'(best_ff) + 33'(cand_sel);
   assign rec_x5    = 34'(rec_ff) * 34'd5;
   assign cand_x3   = 34'(cand_sel) * 34'd3;
   assign round_mid = {rec_ff, 1'b0} > mid_sum;
   assign round_60  = rec_x5 > cand_x3;

   assign status.master_zero = (master_ff == '0);
   assign status.lt_floor    = cand_sel < CAND_W'(FLOOR_LEN);
   assign status.le_rec      = cand_sel <= CAND_W'(rec_ff);
   assign status.round_up    = (phase_mult_ff && first_ff) ? round_60 : round_mid;
   assign status.over_cap    = mult_cand_ff > CAND_W'(MULT_CAP);
   assign status.sub_last    = (sub_idx_ff == SUB_W'(3));
   assign status.out_free    = !rsp_tvalid_ff || rsp_tready;

   assign floor_len = REC_W'(FLOOR_LEN);

   always_comb begin
      span = (stop_ff > start_ff) ? (stop_ff - start_ff) : '0;
      clamp_len = (span > BLOCK_W'(rec_ff)) ? rec_ff : span[REC_W-1:0];
      if (clamp_len < floor_len) begin
         direct_len = (rec_ff >= floor_len) ? floor_len : rec_ff;
      end else begin
         direct_len = clamp_len;
      end
      if (direct_len == '0) begin
         direct_len = REC_W'(1);
      end
   end

   always_comb begin
      master_in     = csr_valid ? csr_data : master_ff;
      sub_idx_in    = sub_idx_ff;
      mult_cand_in  = mult_cand_ff;
      first_in      = first_ff;
      phase_mult_in = phase_mult_ff;
      best_in       = best_ff;
      target_in     = target_ff;
      fits_in       = fits_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      if (cmd.load) begin
         sub_idx_in    = '0;
         mult_cand_in  = CAND_W'(master_ff);
         first_in      = 1'b1;
         phase_mult_in = 1'b0;
         best_in       = floor_len;
      end
      if (cmd.step_sub) begin
         sub_idx_in = sub_idx_ff + SUB_W'(1);
      end
      if (cmd.enter_mult) begin
         phase_mult_in = 1'b1;
      end
      if (cmd.step_mult) begin
         mult_cand_in = mult_cand_ff << 1;
         first_in     = 1'b0;
      end
      if (cmd.take) begin
         best_in = cand_sel[REC_W-1:0];
      end
      if (cmd.load_out) begin
         target_in     = status.master_zero ? direct_len : best_ff;
         fits_in       = target_in <= rec_ff;
         rsp_tvalid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         master_ff     <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         master_ff     <= master_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         rec_ff   <= req_tdata[30:0];
         start_ff <= req_tdata[62:31];
         stop_ff  <= req_tdata[94:63];
      end
      sub_idx_ff    <= sub_idx_in;
      mult_cand_ff  <= mult_cand_in;
      first_ff      <= first_in;
      phase_mult_ff <= phase_mult_in;
      best_ff       <= best_in;
      target_ff     <= target_in;
      fits_ff       <= fits_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {fits_ff, target_ff};

   a_target_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid_ff |-> target_ff != '0)
      else $error("result length is zero");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (!rsp_tvalid_ff || rsp_tready))
      else $error("pending result overwritten");

   a_take_above_floor: assert property (@(posedge clock) disable iff (reset)
      cmd.take |-> cand_sel >= CAND_W'(FLOOR_LEN))
      else $error("candidate below floor taken");

endmodule

FILE: sv/llq_controller.sv
// Controller: sequences the sub-division and multiple sweeps and hands off the result.
module llq_controller (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  llq_pkg::llq_status_type status,
   output llq_pkg::llq_cmd_type    cmd
);
   import llq_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SUB  = 2'd1;
   localparam logic [1:0] S_MULT = 2'd2;
   localparam logic [1:0] S_DONE = 2'd3;

   logic [1:0] state_ff, state_in;

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = status.master_zero ? S_DONE : S_SUB;
            end
         end
         S_SUB: begin
            if (status.lt_floor || status.le_rec) begin
               cmd.take     = !status.lt_floor;
               cmd.step_sub = 1'b1;
               if (status.sub_last) begin
                  cmd.enter_mult = 1'b1;
                  state_in       = S_MULT;
               end
            end else begin
               cmd.take       = status.round_up;
               cmd.enter_mult = 1'b1;
               state_in       = S_MULT;
            end
         end
         S_MULT: begin
            if (status.over_cap) begin
               state_in = S_DONE;
            end else if (status.lt_floor || status.le_rec) begin
               cmd.take      = !status.lt_floor;
               cmd.step_mult = 1'b1;
            end else begin
               cmd.take = status.round_up;
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: bench/tb_top.sv
// Self-checking testbench for the loop length quantizer: stream driver, monitor and length predictor.
`timescale 1ns / 100ps

module tb_top;
   import llq_pkg::*;

   localparam int CYCLE_LIMIT   = 600000;
   localparam int RANDOM_PHASES = 14;
   localparam int PHASE_ITEMS   = 90;

   typedef struct packed {
      logic [30:0] rec;
      logic [31:0] start_blk;
      logic [31:0] stop_blk;
   } press_type;

   typedef struct packed {
      logic [30:0] target;
      logic        fits;
   } length_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [95:0] req_tdata = '0;  // recorded_blocks[30:0], start_block[62:31], stop_block[94:63]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;       // target_blocks[30:0], fits_recorded[31]
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [30:0] csr_data = '0;

   press_type   press_q [$];
   length_type  length_q [$];
   press_type   cur_press;
   length_type  want;
   logic [30:0] master_model = '0;
   int          gap_max = 0;
   int          stall_max = 0;
   int          send_gap = 0;
   int          hold_left = 0;
   int          mismatch_cnt = 0;
   int          cycle_cnt = 0;
   logic        valid_nxt;
   logic        ready_nxt;

   loop_length_quantizer DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   function automatic length_type quantize_length(input logic [30:0] master, input press_type p);
      longint unsigned m, rec, len, best, c, lim, mult;
      longint unsigned cand [4];
      length_type res;
      m = master;
      rec = p.rec;
      if (m == 0) begin
         len = 0;
         if (p.stop_blk > p.start_blk) len = p.stop_blk - p.start_blk;
         if (len > rec) len = rec;
         if (len < FLOOR_LEN) len = (rec >= FLOOR_LEN) ? FLOOR_LEN : rec;
         if (len == 0) len = 1;
         best = len;
      end else begin
         best = FLOOR_LEN;
         cand[0] = FLOOR_LEN;
         cand[1] = m / 8;
         cand[2] = m / 4;
         cand[3] = m / 2;
         for (int i = 0; i < 4; i++) begin
            if (cand[i] < FLOOR_LEN) continue;
            if (cand[i] <= rec) begin
               best = cand[i];
            end else begin
               if (rec * 2 > best + cand[i]) best = cand[i];
               break;
            end
         end
         lim = MULT_CAP / m;
         for (mult = 1; mult <= lim; mult = mult << 1) begin
            c = m * mult;
            if (c < FLOOR_LEN) continue;
            if (c <= rec) begin
               best = c;
               continue;
            end
            if (mult == 1) begin
               if (rec * 5 > c * 3) best = c;
            end else if (rec * 2 > best + c) begin
               best = c;
            end
            break;
         end
      end
      res.target = best[30:0];
      res.fits   = (best <= rec);
      return res;
   endfunction

   task automatic flag(input string msg);
      mismatch_cnt++;
      if (mismatch_cnt <= 10) $display("MISMATCH: %s", msg);
   endtask

   task automatic push_press(input longint rec, input logic [31:0] a, input logic [31:0] b);
      press_type p;
      p.rec = rec[30:0];
      p.start_blk = a;
      p.stop_blk = b;
      press_q.push_back(p);
   endtask

   task automatic wait_idle();
      do @(negedge clock);
      while (press_q.size() != 0 || req_tvalid || length_q.size() != 0);
   endtask

   // Drain, then set master length and idle profile for the next phase.
   task automatic start_phase(input logic [30:0] m, input int gmax, input int smax);
      wait_idle();
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data <= m;
      do @(posedge clock);
      while (!csr_ready);
      master_model = m;
      csr_valid <= 1'b0;
      gap_max = gmax;
      stall_max = smax;
   endtask

   // Request driver.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap = 0;
      end else begin
         valid_nxt = req_tvalid;
         if (req_tvalid && req_tready) begin
            length_q.push_back(quantize_length(master_model, cur_press));
            valid_nxt = 1'b0;
            send_gap = $urandom_range(0, gap_max);
         end
         if (!valid_nxt) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (press_q.size() != 0) begin
               cur_press = press_q.pop_front();
               req_tdata <= {1'b0, cur_press.stop_blk, cur_press.start_blk, cur_press.rec};
               valid_nxt = 1'b1;
            end
         end
         req_tvalid <= valid_nxt;
      end
   end

   // Result monitor.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         hold_left = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (length_q.size() == 0) begin
               flag($sformatf("unexpected result target=%0d fits=%0d",
                              rsp_tdata[30:0], rsp_tdata[31]));
            end else begin
               want = length_q.pop_front();
               if (rsp_tdata[30:0] !== want.target)
                  flag($sformatf("target_blocks expected %0d got %0d (master %0d)",
                                 want.target, rsp_tdata[30:0], master_model));
               if (rsp_tdata[31] !== want.fits)
                  flag($sformatf("fits_recorded expected %0d got %0d (target %0d)",
                                 want.fits, rsp_tdata[31], want.target));
            end
            hold_left = $urandom_range(0, stall_max);
         end
         ready_nxt = 1'b1;
         if (hold_left > 0) begin
            hold_left--;
            ready_nxt = 1'b0;
         end
         rsp_tready <= ready_nxt;
      end
   end

   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt >= CYCLE_LIMIT) begin
         $display("tb_top: done, errors");
         $finish;
      end
   end

   initial begin
      longint      r, base;
      longint      m;
      logic [31:0] a, b;
      int          k;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // No master: start/stop span, clamp, floor and the 1 rule.
      start_phase('0, 0, 0);
      push_press(0, 0, 0);
      push_press(5, 100, 90);
      push_press(100, 100, 100);
      push_press(100, 0, 32'hFFFF_FFFF);
      push_press(1000, 10, 13);
      push_press(3, 10, 50);
      push_press(31'h7FFF_FFFF, 0, 32'hFFFF_FFFF);
      push_press(1 << 30, 32'h8000_0000, 32'hC000_0000);
      push_press(8, 5, 13);

      // Master 1000: sub-division midpoints, 0.6M rule, multiple midpoints.
      start_phase(31'd1000, 3, 10);
      push_press(0, 7, 9);
      push_press(124, 0, 0);
      push_press(187, 0, 0);
      push_press(188, 0, 0);
      push_press(600, 0, 0);
      push_press(601, 0, 0);
      push_press(1500, 0, 0);
      push_press(1501, 0, 0);
      push_press(1 << 30, 0, 0);

      start_phase(31'd1, 0, 0);
      push_press(0, 0, 0);
      push_press(1 << 30, 0, 0);

      start_phase(31'h4000_0000, 10, 0);
      push_press(1 << 30, 0, 0);
      push_press(7 << 27, 0, 0);

      // Master above 2^30: sub-divisions only.
      start_phase(31'h7FFF_FFFF, 0, 10);
      push_press(31'h7FFF_FFFF, 32'hFFFF_FFFF, 0);
      push_press(300000000, 0, 0);

      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         case (ph)
            0, 10:   m = 0;
            1:       m = $urandom_range(1, 15);
            2:       m = 8;
            3:       m = $urandom_range(16, 4096);
            4:       m = longint'(1) << $urandom_range(3, 29);
            5:       m = $urandom_range(1, 1 << 30);
            6:       m = 1 << 30;
            7:       m = $urandom_range((1 << 30) + 1, 32'h7FFF_FFFF);
            8:       m = 32'h7FFF_FFFF;
            9:       m = 3 * (longint'(1) << $urandom_range(0, 27));
            11:      m = $urandom_range(1, 1 << 20);
            12:      m = 4;
            default: m = $urandom_range(1, 1 << 30);
         endcase
         start_phase(m[30:0], (ph % 2) * 10, ((ph / 2) % 2) * 10);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (m == 0) begin
               base = $urandom_range(8, 1 << 20);
            end else begin
               k = $urandom_range(0, 8);
               base = (k < 3) ? (m >> (k + 1)) : (m << (k - 3));
            end
            case ($urandom_range(0, 7))
               0:       r = $urandom_range(0, 24);
               1:       r = $urandom & 32'h7FFF_FFFF;
               2:       r = $urandom_range(0, 1 << 30);
               3:       r = base * $urandom_range(40, 160) / 100;
               4:       r = base + $urandom_range(0, 4) - 2;
               5:       r = (base * 3) / 2 + $urandom_range(0, 2) - 1;
               6:       r = (base * 3) / 5 + $urandom_range(0, 2) - 1;
               default: r = (base * 3) / 4 + $urandom_range(0, 2) - 1;
            endcase
            if (r < 0) r = 0;
            if (r > 32'h7FFF_FFFF) r = 32'h7FFF_FFFF;
            a = $urandom;
            case ($urandom_range(0, 4))
               0:       b = $urandom;
               1:       b = a + 32'(r) + $urandom_range(0, 4) - 2;
               2:       b = a + 32'(r * $urandom_range(0, 100) / 100);
               3:       b = a + $urandom_range(0, 16);
               default: b = a - $urandom_range(0, 16);
            endcase
            push_press(r, a, b);
         end
      end

      wait_idle();
      repeat (60) @(posedge clock);
      if (mismatch_cnt == 0 && length_q.size() == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end

endmodule
